@@ src/assert_macros.svh @@
// Assertion macros used by the stack engine datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BSE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("stack engine assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define BSE_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("stack engine forbidden condition seen");
`else
`define BSE_ASSERT(lbl, clk, rstn, prop)
`define BSE_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ src/bse_pkg.sv @@
// Package with the types, codes and constants of the bounded stack engine.
`default_nettype none
package bse_pkg;

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int CAP_W              = 7;
    localparam int PUSH_W             = 32;
    localparam int RES_W              = 38;
    localparam int OP_W               = 3;
    localparam int STAT_W             = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_PEEK = 3'd2,
        OP_DUMP = 3'd3,
        OP_SUM  = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEL_VALUE = 2'd0,
        SEL_RAM   = 2'd1,
        SEL_ACC   = 2'd2,
        SEL_ZERO  = 2'd3
    } out_sel_t;

    typedef struct packed {
        logic     capture;
        logic     push_wr;
        logic     pop_dec;
        logic     rd_top;
        logic     rd_next;
        logic     acc_clr;
        logic     acc_add;
        logic     out_load;
        out_sel_t out_sel;
        status_t  out_status;
        logic     out_last;
    } bse_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic ptr_zero;
        logic out_free;
    } bse_sts_t;

endpackage
`default_nettype wire

@@ src/bse_datapath.sv @@
// Datapath of the stack engine: entry memory, fill count, walk pointer, sum and output register.
`default_nettype none
`include "assert_macros.svh"
module bse_datapath
    import bse_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata,
    input  wire logic [PUSH_W-1:0] push_value,
    input  wire bse_cmd_t          cmd,
    output bse_sts_t               sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [RES_W-1:0]       m_data,
    output logic [STAT_W-1:0]      m_status,
    output logic                   m_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [FW-1:0]         fill_reg, fill_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [RES_W-1:0]      acc_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic                  valid_reg, valid_next;
    logic [RES_W-1:0]      data_reg;
    logic [STAT_W-1:0]     status_reg;
    logic                  last_reg;
    logic [AW-1:0]         top_addr;
    logic [AW-1:0]         rd_addr;
    logic [RES_W-1:0]      out_value;

    function automatic logic [RES_W-1:0] sext(input logic [DATA_WIDTH-1:0] w);
        sext = {{(RES_W - DATA_WIDTH){w[DATA_WIDTH-1]}}, w};
    endfunction

    assign top_addr = AW'(fill_reg - FW'(1));
    assign rd_addr  = cmd.rd_top ? top_addr : AW'(ptr_reg - AW'(1));

    always_comb begin
        fill_next = fill_reg;
        if (cmd.push_wr) begin
            fill_next = fill_reg + FW'(1);
        end else if (cmd.pop_dec) begin
            fill_next = fill_reg - FW'(1);
        end
        ptr_next = ptr_reg;
        if (cmd.rd_top || cmd.rd_next) begin
            ptr_next = rd_addr;
        end
    end

    always_comb begin
        case (cmd.out_sel)
            SEL_VALUE: out_value = sext(val_reg);
            SEL_RAM:   out_value = sext(rd_data_reg);
            SEL_ACC:   out_value = acc_reg;
            default:   out_value = '0;
        endcase
    end

    assign sts.empty    = (fill_reg == '0);
    assign sts.full     = (CAP_W'(fill_reg) >= cap_reg) || (fill_reg == FILL_MAX);
    assign sts.ptr_zero = (ptr_reg == '0);
    assign sts.out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            mem[AW'(fill_reg)] <= push_value[DATA_WIDTH-1:0];
        end
        if (cmd.rd_top || cmd.rd_next) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            ptr_reg   <= '0;
            cap_reg   <= CAP_RESET;
            valid_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            val_reg <= push_value[DATA_WIDTH-1:0];
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + sext(rd_data_reg);
        end
        if (cmd.out_load) begin
            data_reg   <= out_value;
            status_reg <= cmd.out_status;
            last_reg   <= cmd.out_last;
        end
    end

    assign m_valid  = valid_reg;
    assign m_data   = data_reg;
    assign m_status = status_reg;
    assign m_last   = last_reg;

    `BSE_NEVER(a_fill_bound, aclk, aresetn, fill_reg > FILL_MAX)
    `BSE_ASSERT(a_push_room, aclk, aresetn, cmd.push_wr |-> !sts.full)
    `BSE_ASSERT(a_pop_nonempty, aclk, aresetn, (cmd.pop_dec || cmd.rd_top) |-> !sts.empty)
    `BSE_ASSERT(a_load_free, aclk, aresetn, cmd.out_load |-> sts.out_free)

endmodule
`default_nettype wire

@@ src/bse_ctrl.sv @@
// Controller state machine of the stack engine.
`default_nettype none
module bse_ctrl
    import bse_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [OP_W-1:0] opcode,
    input  wire bse_sts_t        sts,
    output bse_cmd_t             cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_DUMP,
        S_SUM
    } state_t;

    state_t   state_reg, state_next;
    out_sel_t sel_reg, sel_next;
    status_t  status_reg, status_next;
    logic     accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.out_sel    = sel_reg;
        cmd.out_status = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    case (opcode)
                        OP_PUSH: begin
                            cmd.push_wr = !sts.full;
                            sel_next    = SEL_VALUE;
                            status_next = sts.full ? STAT_OVERFLOW : STAT_OK;
                            state_next  = S_EMIT;
                        end
                        OP_POP, OP_PEEK, OP_DUMP, OP_SUM: begin
                            if (sts.empty) begin
                                sel_next    = SEL_ZERO;
                                status_next = STAT_EMPTY;
                                state_next  = S_EMIT;
                            end else begin
                                cmd.rd_top  = 1'b1;
                                sel_next    = SEL_RAM;
                                status_next = STAT_OK;
                                if (opcode == OP_POP) begin
                                    cmd.pop_dec = 1'b1;
                                    state_next  = S_EMIT;
                                end else if (opcode == OP_PEEK) begin
                                    state_next  = S_EMIT;
                                end else if (opcode == OP_DUMP) begin
                                    state_next  = S_DUMP;
                                end else begin
                                    cmd.acc_clr = 1'b1;
                                    state_next  = S_SUM;
                                end
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = SEL_RAM;
                    cmd.out_status = STAT_OK;
                    cmd.out_last   = sts.ptr_zero;
                    if (sts.ptr_zero) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            S_SUM: begin
                cmd.acc_add = 1'b1;
                if (sts.ptr_zero) begin
                    sel_next    = SEL_ACC;
                    status_next = STAT_OK;
                    state_next  = S_EMIT;
                end else begin
                    cmd.rd_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            sel_reg    <= SEL_ZERO;
            status_reg <= STAT_OK;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            status_reg <= status_next;
        end
    end

endmodule
`default_nettype wire

@@ src/bounded_stack_engine.sv @@
// Top level of the bounded stack engine: controller plus datapath behind stream ports.
//
// Usage: each transaction on the s_ channel carries one command. Opcode push stores
// push_value on top of the stack, pop returns and removes the top entry, peek returns
// it, dump returns every entry from top to bottom, and sum returns their exact total.
// Every command yields one or more transactions on the m_ channel; the final one has
// m_tlast set and m_tuser carries the status (ok, overflow or empty). Opcodes 5 to 7
// are consumed and yield nothing.
// Sequencing: push, pop and peek pass through the emit state, which loads the result
// into the output register once that register is free; only then does the engine
// return to idle and take the next command. Dump and sum walk the stack through the
// single read port of the entry memory, one entry a cycle, and a dump walk pauses
// whenever the output register is not free.
// The capacity register may be written at any time the engine is idle; it resets to 64.
// Reset empties the stack at once; entry contents are not cleared and need no pass.
// When the receiver stalls, the result is held in the output register and the engine
// waits; a dump resumes its walk as soon as the output register is taken.
`default_nettype none
module bounded_stack_engine
    import bse_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // Configuration: capacity register.
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    // Command stream.
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [39:0]      s_tdata,   // opcode [2:0], push_value [34:3], zero pad
    // Result stream.
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [39:0]           m_tdata,   // data [37:0], zero pad
    output logic [STAT_W-1:0]     m_tuser,   // status [1:0]
    output logic                  m_tlast
);

    bse_cmd_t         cmd;
    bse_sts_t         sts;
    logic [RES_W-1:0] res_data;

    // The controller decides each cycle what the datapath does with a transaction.
    bse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .opcode  (s_tdata[OP_W-1:0]),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath owns the entries, the fill count and the output register.
    bse_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push_value (s_tdata[OP_W +: PUSH_W]),
        .cmd        (cmd),
        .sts        (sts),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (res_data),
        .m_status   (m_tuser),
        .m_last     (m_tlast)
    );

    assign m_tdata = {2'b00, res_data};

endmodule
`default_nettype wire
